// ===== hdl/mvt_pkg.sv =====
// Shared types and constants for the 4x4 matrix-vector transform engine.
// No dependencies; compile this file first.
package mvt_pkg;

    localparam int ELEM_W        = 16;
    localparam int DIM           = 4;
    localparam int FRAC_BITS_DEF = 8;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_XFORM = 1'b1;

    localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7FFF;
    localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;

    typedef logic signed [ELEM_W-1:0] elem_t;

    typedef struct packed {
        logic       kind;
        logic [1:0] row;
        logic [1:0] col;
        elem_t      element;
        elem_t      vec_x;
        elem_t      vec_y;
        elem_t      vec_z;
        elem_t      vec_w;
    } cmd_item_t;

    typedef struct packed {
        elem_t out_x;
        elem_t out_y;
        elem_t out_z;
        elem_t out_w;
        logic  saturated;
    } res_item_t;

endpackage

// ===== hdl/mvt_cmd_if.sv =====
// Valid/ready channel carrying load and transform requests.
// Depends on mvt_pkg for the request type.
interface mvt_cmd_if;
    logic                valid;
    logic                ready;
    mvt_pkg::cmd_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/mvt_res_if.sv =====
// Valid/ready channel carrying transform results.
// Depends on mvt_pkg for the result type.
interface mvt_res_if;
    logic                valid;
    logic                ready;
    mvt_pkg::res_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/matrix_vector_transform_4x4.sv =====
// Once accepted, a transform request passes the multiply stage, the row-sum
// stage and the round/saturate output register in turn. Throughput: one
// request per cycle while no result is held back; a load writes the matrix at
// acceptance and is seen by a transform accepted in the very next cycle.
// Result back-pressure stalls the whole pipe. Reset: matrix returns to
// identity, pipeline empties. Depends on mvt_pkg, mvt_cmd_if and mvt_res_if.
module matrix_vector_transform_4x4 #(
    parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    mvt_cmd_if.sink     cmd,
    mvt_res_if.source   result
);

    localparam int ELEM_W = mvt_pkg::ELEM_W;
    localparam int DIM    = mvt_pkg::DIM;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int SUM_W  = PROD_W + 3;

    localparam logic signed [ELEM_W-1:0] IDENT = ELEM_W'(64'd1 << FRAC_BITS);
    localparam logic signed [SUM_W-1:0]  ROUND_C = SUM_W'((64'd1 << FRAC_BITS) >> 1);

    logic advance;
    logic accept;

    logic signed [ELEM_W-1:0] matrix_reg [DIM*DIM];
    logic signed [ELEM_W-1:0] vec_in     [DIM];

    logic signed [PROD_W-1:0] prod_next [DIM][DIM];
    logic signed [PROD_W-1:0] prod_reg  [DIM][DIM];
    logic                     s1_valid_reg;

    logic signed [SUM_W-1:0]  sum_next [DIM];
    logic signed [SUM_W-1:0]  sum_reg  [DIM];
    logic                     s2_valid_reg;

    logic signed [SUM_W-1:0]  rnd      [DIM];
    logic signed [ELEM_W-1:0] clip_val [DIM];
    logic [DIM-1:0]           clip_hit;

    mvt_pkg::res_item_t       res_next;
    mvt_pkg::res_item_t       res_reg;
    logic                     res_valid_reg;

    // Hold everything while a finished result waits.
    assign advance   = !res_valid_reg || result.ready;
    assign accept    = cmd.valid && advance;
    assign cmd.ready = advance;

    assign vec_in[0] = cmd.data.vec_x;
    assign vec_in[1] = cmd.data.vec_y;
    assign vec_in[2] = cmd.data.vec_z;
    assign vec_in[3] = cmd.data.vec_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIM*DIM; i++)
            begin
                matrix_reg[i] <= (i % (DIM + 1) == 0) ? IDENT : '0;
            end
        end
        else if (accept && cmd.data.kind == mvt_pkg::KIND_LOAD)
        begin
            matrix_reg[{cmd.data.row, cmd.data.col}] <= cmd.data.element;
        end
    end

    always_comb
    begin
        for (int r = 0; r < DIM; r++)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                prod_next[r][c] = PROD_W'(matrix_reg[r*DIM+c]) * PROD_W'(vec_in[c]);
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < DIM; r++)
        begin
            sum_next[r] = SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1])
                        + SUM_W'(prod_reg[r][2]) + SUM_W'(prod_reg[r][3]);
        end
    end

    // Round half up, then clip to the element range.
    always_comb
    begin
        for (int r = 0; r < DIM; r++)
        begin
            rnd[r] = (sum_reg[r] + ROUND_C) >>> FRAC_BITS;
            clip_hit[r] = !((&rnd[r][SUM_W-1:ELEM_W-1]) || !(|rnd[r][SUM_W-1:ELEM_W-1]));
            if (clip_hit[r])
            begin
                clip_val[r] = rnd[r][SUM_W-1] ? mvt_pkg::ELEM_MIN : mvt_pkg::ELEM_MAX;
            end
            else
            begin
                clip_val[r] = rnd[r][ELEM_W-1:0];
            end
        end
        res_next.out_x     = clip_val[0];
        res_next.out_y     = clip_val[1];
        res_next.out_z     = clip_val[2];
        res_next.out_w     = clip_val[3];
        res_next.saturated = |clip_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= accept && cmd.data.kind == mvt_pkg::KIND_XFORM;
            s2_valid_reg  <= s1_valid_reg;
            res_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
            res_reg  <= res_next;
        end
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

`ifndef NO_ASSERTIONS
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.data.kind == mvt_pkg::KIND_LOAD) |=> !s1_valid_reg)
        else $error("load request entered the transform pipeline");

    a_xform_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.data.kind == mvt_pkg::KIND_XFORM) |=> s1_valid_reg)
        else $error("transform request lost at pipeline entry");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable({s1_valid_reg, s2_valid_reg, res_valid_reg}))
        else $error("pipeline valid bits moved during a stall");

    a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && advance) |=> res_valid_reg)
        else $error("row sums dropped before the output register");
`endif

endmodule
